@@ rtl/dpd_pkg.sv @@
// Shared types, constants and calendar helpers for the days-past-due-date block.
package dpd_pkg;

  localparam int DayW  = 5;
  localparam int MonW  = 4;
  localparam int YearW = 12;
  localparam int DaysW = 21;
  localparam int AccW  = 23;
  localparam int IdxW  = 2;
  localparam int CfgW  = 12;
  localparam int ResW  = 5;
  localparam int YlenW = 9;

  // Reset values of the current date
  localparam logic [DayW-1:0]  TodayDayRst   = 5'd1;
  localparam logic [MonW-1:0]  TodayMonthRst = 4'd1;
  localparam logic [YearW-1:0] TodayYearRst  = 12'd2024;

  // Calendar constants
  localparam logic [MonW-1:0]  MonthFirst   = 4'd1;
  localparam logic [MonW-1:0]  MonthLast    = 4'd12;
  localparam logic [MonW-1:0]  MonthFeb     = 4'd2;
  localparam logic [DayW-1:0]  DaysLeapFeb  = 5'd29;
  localparam logic [YlenW-1:0] YearDays     = 9'd365;
  localparam logic [YlenW-1:0] YearDaysLeap = 9'd366;
  localparam logic [ResW-1:0]  Mod25Last    = 5'd24;

  // Reciprocal of 25 scaled by 2^17, exact for every 12-bit year
  localparam logic [12:0] Mod25Mul   = 13'd5243;
  localparam int          Mod25Shift = 17;

  // Months 0 and 13..15 hold no days
  localparam logic [DayW-1:0] MONTH_DAYS [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  typedef enum logic [IdxW-1:0] {
    CFG_TODAY_DAY   = 2'd0,
    CFG_TODAY_MONTH = 2'd1,
    CFG_TODAY_YEAR  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP_TODAY,
    ST_LEAP_DUE,
    ST_TODAY_MON,
    ST_DUE_MON,
    ST_YEARS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } date_t;

  typedef struct packed {
    logic             load;
    logic [DaysW-1:0] days;
    logic             invalid;
  } res_t;

  // Leap test from the year and its residue mod 25
  function automatic logic is_leap(logic [YearW-1:0] y, logic [ResW-1:0] r25);
    return (y[1:0] == 2'b00) && ((r25 != '0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] month_len(logic [MonW-1:0] m, logic leap);
    logic [DayW-1:0] n;
    n = MONTH_DAYS[m];
    if ((m == MonthFeb) && leap) n = DaysLeapFeb;
    return n;
  endfunction

  function automatic logic [YlenW-1:0] year_len(logic leap);
    return leap ? YearDaysLeap : YearDays;
  endfunction

endpackage

@@ rtl/days_past_due_date.sv @@
// Top level of the days-past-due-date block: configuration, stream ports, result register.
//
// Each input transaction carries a due date; the block returns how many days the current
// date (held in the three configuration registers) lies past it, or 0 when the due date is
// today or later, and flags a due month outside 1..12. One shared adder accumulates month
// lengths of today's year, subtracts those of the due year, then adds one whole year per
// cycle; leap years come from a shared mod-25 unit used in two setup states. The input side
// is ready only while the sequencer is idle; the result register lets the next item be
// taken while a finished result still waits on the output side.
module days_past_due_date (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [dpd_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [dpd_pkg::CfgW-1:0]  cfg_data_i,
  // Input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // due_day[4:0], due_month[8:5], due_year[20:9]
  // Output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // days_late[20:0]
  output logic [0:0]                m_axis_tuser   // date_invalid[0]
);
  import dpd_pkg::*;

  logic [DayW-1:0]  today_day_q;
  logic [MonW-1:0]  today_month_q;
  logic [YearW-1:0] today_year_q;
  logic             out_vld_q;
  logic [DaysW-1:0] out_days_q;
  logic             out_inv_q;
  date_t            in_date;
  date_t            today;
  res_t             res;
  logic             out_free;

  assign cfg_ready_o = 1'b1;

  // Write the current date
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      today_day_q   <= TodayDayRst;
      today_month_q <= TodayMonthRst;
      today_year_q  <= TodayYearRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TODAY_DAY)   today_day_q   <= cfg_data_i[DayW-1:0];
      if (cfg_index_i == CFG_TODAY_MONTH) today_month_q <= cfg_data_i[MonW-1:0];
      if (cfg_index_i == CFG_TODAY_YEAR)  today_year_q  <= cfg_data_i[YearW-1:0];
    end
  end

  assign in_date.day   = s_axis_tdata[4:0];
  assign in_date.month = s_axis_tdata[8:5];
  assign in_date.year  = s_axis_tdata[20:9];
  assign today.day     = today_day_q;
  assign today.month   = today_month_q;
  assign today.year    = today_year_q;
  assign out_free      = !out_vld_q || m_axis_tready;

  dpd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_date_i  (in_date),
    .today_i    (today),
    .out_free_i (out_free),
    .res_o      (res)
  );

  // Hold the result until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_days_q <= res.days;
      out_inv_q  <= res.invalid;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_days_q};
  assign m_axis_tuser  = out_inv_q;

endmodule

@@ rtl/dpd_mod25.sv @@
// Shared residue unit: a year modulo 25 by reciprocal multiplication.
module dpd_mod25 (
  input  logic [dpd_pkg::YearW-1:0] year_i,
  output logic [dpd_pkg::ResW-1:0]  res_o
);
  import dpd_pkg::*;

  logic [YearW+12:0] prod;
  logic [7:0]        quot;
  logic [YearW-1:0]  quot25;
  logic [YearW-1:0]  rem;

  // Quotient by scaled reciprocal, then remainder by shift-and-add
  assign prod   = {13'b0, year_i} * {{YearW{1'b0}}, Mod25Mul};
  assign quot   = prod[Mod25Shift+7:Mod25Shift];
  assign quot25 = ({4'b0, quot} << 4) + ({4'b0, quot} << 3) + {4'b0, quot};
  assign rem    = year_i - quot25;
  assign res_o  = rem[ResW-1:0];

endmodule

@@ rtl/dpd_core.sv @@
// Sequencer and shared accumulator that count the days between two dates.
module dpd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dpd_pkg::date_t in_date_i,
  input  dpd_pkg::date_t today_i,
  input  logic          out_free_i,
  output dpd_pkg::res_t res_o
);
  import dpd_pkg::*;

  state_e                state_q, state_d;
  date_t                 due_q, due_d;
  logic                  inv_q, inv_d;
  logic [MonW-1:0]       mon_q, mon_d;
  logic [YearW-1:0]      year_q, year_d;
  logic [ResW-1:0]       r25_q, r25_d;
  logic                  tleap_q, tleap_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] opnd;
  logic [YearW-1:0]      mod_year;
  logic [ResW-1:0]       mod_res;
  logic                  month_bad;
  logic                  earlier;
  logic                  yleap;
  logic [YearW:0]        year_nxt;
  logic [DaysW-1:0]      days_sat;

  dpd_mod25 u_mod25 (
    .year_i (mod_year),
    .res_o  (mod_res)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign month_bad  = (in_date_i.month < MonthFirst) || (in_date_i.month > MonthLast);
  assign yleap      = is_leap(year_q, r25_q);
  assign year_nxt   = {1'b0, year_q} + {{YearW{1'b0}}, 1'b1};

  // Due date strictly earlier than today
  always_comb begin
    if (in_date_i.year != today_i.year) begin
      earlier = in_date_i.year < today_i.year;
    end else if (in_date_i.month != today_i.month) begin
      earlier = in_date_i.month < today_i.month;
    end else begin
      earlier = in_date_i.day < today_i.day;
    end
  end

  // Clamp the count to the result range
  always_comb begin
    if (acc_q[AccW-1]) begin
      days_sat = '0;
    end else if (acc_q[AccW-2:DaysW] != '0) begin
      days_sat = '1;
    end else begin
      days_sat = acc_q[DaysW-1:0];
    end
  end

  // Next state, operand select and shared add
  always_comb begin
    state_d  = state_q;
    due_d    = due_q;
    inv_d    = inv_q;
    mon_d    = mon_q;
    year_d   = year_q;
    r25_d    = r25_q;
    tleap_d  = tleap_q;
    opnd     = '0;
    mod_year = today_i.year;
    res_o    = '{load: 1'b0, days: days_sat, invalid: inv_q};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          due_d = in_date_i;
          inv_d = month_bad;
          mon_d = MonthFirst;
          opnd  = -acc_q;
          if (month_bad || !earlier) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_LEAP_TODAY;
          end
        end
      end
      ST_LEAP_TODAY: begin
        mod_year = today_i.year;
        tleap_d  = is_leap(today_i.year, mod_res);
        state_d  = ST_LEAP_DUE;
      end
      ST_LEAP_DUE: begin
        mod_year = due_q.year;
        r25_d    = mod_res;
        year_d   = due_q.year;
        state_d  = ST_TODAY_MON;
      end
      ST_TODAY_MON: begin
        if (mon_q < today_i.month) begin
          opnd  = $signed({{(AccW-DayW){1'b0}}, month_len(mon_q, tleap_q)});
          mon_d = mon_q + MonW'(1);
        end else begin
          opnd    = $signed({{(AccW-DayW){1'b0}}, today_i.day});
          mon_d   = MonthFirst;
          state_d = ST_DUE_MON;
        end
      end
      ST_DUE_MON: begin
        if (mon_q < due_q.month) begin
          opnd  = -$signed({{(AccW-DayW){1'b0}}, month_len(mon_q, yleap)});
          mon_d = mon_q + MonW'(1);
        end else begin
          opnd = -$signed({{(AccW-DayW){1'b0}}, due_q.day});
          if (due_q.year == today_i.year) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_YEARS;
          end
        end
      end
      ST_YEARS: begin
        // Add one whole year from the due year up to the year before today
        opnd   = $signed({{(AccW-YlenW){1'b0}}, year_len(yleap)});
        year_d = year_nxt[YearW-1:0];
        r25_d  = (r25_q == Mod25Last) ? '0 : r25_q + ResW'(1);
        if (year_nxt == {1'b0, today_i.year}) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    acc_d = acc_q + opnd;
  end

  // Hold sequencer state and the accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Hold working registers
  always_ff @(posedge clk_i) begin
    due_q   <= due_d;
    inv_q   <= inv_d;
    mon_q   <= mon_d;
    year_q  <= year_d;
    r25_q   <= r25_d;
    tleap_q <= tleap_d;
  end

endmodule

@@ rtl/dpd_checker.sv @@
// Port-level checks for the days-past-due-date block, bound to the top level.
module dpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Drop input ready after an input transaction while the item is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready stayed high after an accepted item");

  // An invalid date never reports a day count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
    else $error("invalid date reported with a nonzero day count");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind days_past_due_date dpd_checker u_dpd_checker (.*);

@@ dv/overdue_checker.sv @@
// Checker for the days-past-due-date block: predicts each result and compares it on arrival.
module overdue_checker
  import dpd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            due_valid_i,
  input  logic            due_ready_i,
  input  logic [23:0]     due_data_i,    // due_day[4:0], due_month[8:5], due_year[20:9]
  input  logic            late_valid_i,
  input  logic            late_ready_i,
  input  logic [23:0]     late_data_i,   // days_late[20:0]
  input  logic [0:0]      late_user_i,   // date_invalid[0]
  output int              mismatch_count_o,
  output int              pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Month lengths; months 0 and 13..15 hold no days
  localparam int MonthDays [16] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0};

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic             invalid;
  } late_t;

  late_t            late_q [$];
  logic [DayW-1:0]  now_day;
  logic [MonW-1:0]  now_month;
  logic [YearW-1:0] now_year;
  int               errors;

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint days_in_month(int unsigned m, int unsigned y);
    if (m == 2 && leap_year(y)) return 29;
    return MonthDays[m];
  endfunction

  // Day d plus all whole months before month m
  function automatic longint ordinal(int unsigned d, int unsigned m, int unsigned y);
    longint s;
    s = d;
    for (int unsigned k = 1; k < m; k++) s += days_in_month(k, y);
    return s;
  endfunction

  function automatic longint year_length(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic late_t predict_late(logic [DayW-1:0] dd, logic [MonW-1:0] dm,
                                         logic [YearW-1:0] dy);
    late_t  r;
    bit     earlier;
    longint span;
    r = '0;
    // Invalid due month: flag it and skip the comparison
    if (dm < 1 || dm > 12) begin
      r.invalid = 1'b1;
      return r;
    end
    if (dy != now_year) earlier = dy < now_year;
    else if (dm != now_month) earlier = dm < now_month;
    else earlier = dd < now_day;
    if (!earlier) return r;
    if (dy == now_year) begin
      span = ordinal(now_day, now_month, now_year) - ordinal(dd, dm, dy);
    end else begin
      span = year_length(dy) - ordinal(dd, dm, dy);
      for (int unsigned y = dy + 1; y < now_year; y++) span += year_length(y);
      span += ordinal(now_day, now_month, now_year);
    end
    // Saturate negative counts at zero and counts beyond the result width at its maximum
    if (span < 0) span = 0;
    if (span > (longint'(1) << DaysW) - 1) span = (longint'(1) << DaysW) - 1;
    r.days = span[DaysW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    late_t want;
    late_t seen;
    if (!rst_ni) begin
      now_day   = 5'd1;
      now_month = 4'd1;
      now_year  = 12'd2024;
      late_q.delete();
      errors = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // Apply register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TODAY_DAY:   now_day   = cfg_data_i[DayW-1:0];
          CFG_TODAY_MONTH: now_month = cfg_data_i[MonW-1:0];
          CFG_TODAY_YEAR:  now_year  = cfg_data_i[YearW-1:0];
          default: ;
        endcase
      end
      // Compare each result transaction with the oldest prediction
      if (late_valid_i && late_ready_i) begin
        seen.days    = late_data_i[DaysW-1:0];
        seen.invalid = late_user_i[0];
        if (late_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: days_late %0d date_invalid %0b",
                     seen.days, seen.invalid);
        end else begin
          want = late_q.pop_front();
          if (seen.days !== want.days || seen.invalid !== want.invalid) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: days_late %0d (expected %0d), %s %0b (expected %0b)",
                       seen.days, want.days, "date_invalid", seen.invalid, want.invalid);
          end
        end
      end
      // Predict each accepted due date and queue it behind the older ones
      if (due_valid_i && due_ready_i)
        late_q = {late_q, predict_late(due_data_i[DayW-1:0],
                                       due_data_i[DayW+MonW-1:DayW],
                                       due_data_i[DayW+MonW+YearW-1:DayW+MonW])};
      mismatch_count_o <= errors;
      pending_count_o  <= late_q.size();
    end
  end

endmodule

@@ dv/days_past_due_date_test.sv @@
// Testbench top for the days-past-due-date block: clock, reset, stimulus and verdict.
module days_past_due_date_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dpd_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [IdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]  cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata;   // due_day[4:0], due_month[8:5], due_year[20:9]
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [23:0]      m_axis_tdata;   // days_late[20:0]
  logic [0:0]       m_axis_tuser;   // date_invalid[0]
  int               mismatches;
  int               pending;
  bit               sender_gaps;
  bit               receiver_stalls;
  bit               hold_off_req;
  logic [DayW-1:0]  cur_day;
  logic [MonW-1:0]  cur_month;
  logic [YearW-1:0] cur_year;

  days_past_due_date dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  overdue_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .due_valid_i      (s_axis_tvalid),
    .due_ready_i      (s_axis_tready),
    .due_data_i       (s_axis_tdata),
    .late_valid_i     (m_axis_tvalid),
    .late_ready_i     (m_axis_tready),
    .late_data_i      (m_axis_tdata),
    .late_user_i      (m_axis_tuser),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (500) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one due date and hold it until accepted
  task automatic send_due(input logic [DayW-1:0] d, input logic [MonW-1:0] m,
                          input logic [YearW-1:0] y);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, y, m, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all three date registers once the block is idle
  task automatic set_today(input logic [DayW-1:0] d, input logic [MonW-1:0] m,
                           input logic [YearW-1:0] y);
    logic [CfgW-1:0] vals [3];
    cfg_idx_e        idx  [3];
    drain_results();
    // Junk in the unused upper bits must be dropped
    vals[0] = {7'($urandom), d};
    vals[1] = {8'($urandom), m};
    vals[2] = y;
    idx     = '{CFG_TODAY_DAY, CFG_TODAY_MONTH, CFG_TODAY_YEAR};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_day   = d;
    cur_month = m;
    cur_year  = y;
  endtask

  // Mostly due dates a few years back; some later, some invalid, a few far away
  task automatic send_random_due();
    int unsigned pick;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned back;
    pick = $urandom_range(0, 99);
    mo   = $urandom_range(1, 12);
    dy   = $urandom_range(1, 28);
    back = $urandom_range(0, 24);
    yr   = (cur_year > back) ? cur_year - back : 0;
    if (pick < 8) begin
      mo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
      yr = $urandom_range(0, 4095);
    end else if (pick < 12) begin
      yr = $urandom_range(0, 4095);
    end else if (pick < 30) begin
      yr = cur_year + $urandom_range(0, 3);
      if (yr > 4095) yr = 4095;
    end else if (pick < 45 && cur_month >= 1 && cur_month <= 12) begin
      // Same year and month: the day decides
      yr = cur_year;
      mo = cur_month;
    end
    if ($urandom_range(0, 4) == 0) dy = $urandom_range(0, 31);
    send_due(DayW'(dy), MonW'(mo), YearW'(yr));
  endtask

  initial begin : stimulus
    int unsigned td;
    int unsigned tm;
    int unsigned ty;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    hold_off_req    = 1'b0;
    cur_day         = 5'd1;
    cur_month       = 4'd1;
    cur_year        = 12'd2024;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset date: equal, just before, leap centuries, invalid months, far past, later
    send_due(5'd1, 4'd1, 12'd2024);
    send_due(5'd0, 4'd1, 12'd2024);
    send_due(5'd31, 4'd12, 12'd2023);
    send_due(5'd29, 4'd2, 12'd2000);
    send_due(5'd1, 4'd3, 12'd1900);
    send_due(5'd0, 4'd0, 12'd0);
    send_due(5'd31, 4'd13, 12'd4095);
    send_due(5'd31, 4'd15, 12'd0);
    send_due(5'd1, 4'd1, 12'd0);
    send_due(5'd31, 4'd12, 12'd4095);
    send_due(5'd2, 4'd1, 12'd2024);

    // Day past month end gives a negative count that must clamp
    set_today(5'd1, 4'd3, 12'd2024);
    send_due(5'd31, 4'd2, 12'd2024);
    send_due(5'd29, 4'd2, 12'd2024);

    // Top of every field, month beyond the table
    set_today(5'd31, 4'd15, 12'd4095);
    send_due(5'd0, 4'd1, 12'd0);
    send_due(5'd31, 4'd12, 12'd4095);
    send_due(5'd5, 4'd7, 12'd4000);

    // Month zero and day zero: no day of today's year counts, only days of earlier years
    set_today(5'd0, 4'd0, 12'd100);
    send_due(5'd0, 4'd12, 12'd99);
    send_due(5'd0, 4'd1, 12'd100);
    send_due(5'd31, 4'd12, 12'd100);

    // Year zero is a leap year
    set_today(5'd1, 4'd1, 12'd0);
    send_due(5'd0, 4'd1, 12'd0);
    send_due(5'd31, 4'd12, 12'd0);

    // Random phases, each under its own date; the last one runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      td = $urandom_range(1, 28);
      tm = $urandom_range(1, 12);
      ty = $urandom_range(0, 4095);
      if ($urandom_range(0, 3) == 0) begin
        td = $urandom_range(0, 31);
        tm = $urandom_range(0, 15);
      end
      set_today(DayW'(td), MonW'(tm), YearW'(ty));
      if (ph == 7) begin
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
      end
      if (ph == 1) hold_off_req = 1'b1;
      repeat (106) send_random_due();
    end

    drain_results();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ days_past_due_date.f @@
rtl/dpd_pkg.sv
rtl/dpd_mod25.sv
rtl/dpd_core.sv
rtl/days_past_due_date.sv
rtl/dpd_checker.sv
dv/overdue_checker.sv
dv/days_past_due_date_test.sv
